// ===== rtl/core/aes_pkg.sv =====
package aes_pkg;

	localparam int NumRounds = 10;
	localparam int CfgIdxW   = 1;

	typedef logic [127:0] blk_t;

	// Register indexes of the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} reg_idx_t;

	// Forward S-box
	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// Round constants for rounds 1..10 (index 0 unused)
	localparam logic [7:0] RCON [NumRounds+1] = '{
		8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte n of a block, byte 0 in the top bits
	function automatic logic [7:0] get_byte(input blk_t b, input int n);
		get_byte = b[127-8*n -: 8];
	endfunction

	// SubBytes and ShiftRows
	function automatic blk_t sub_shift(input blk_t s);
		blk_t t;
		t = '0;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[127-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
		sub_shift = t;
	endfunction

	function automatic blk_t mix_columns(input blk_t s);
		blk_t t;
		logic [7:0] a0, a1, a2, a3, al;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, 4*c);
			a1 = get_byte(s, 4*c+1);
			a2 = get_byte(s, 4*c+2);
			a3 = get_byte(s, 4*c+3);
			al = a0 ^ a1 ^ a2 ^ a3;
			t[127-8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
			t[127-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
			t[127-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			t[127-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		mix_columns = t;
	endfunction

	// Next round key from the previous one
	function automatic blk_t next_key(input blk_t k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, tw;
		w0 = k[127:96];
		w1 = k[95:64];
		w2 = k[63:32];
		w3 = k[31:0];
		tw = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
		w0 = w0 ^ tw;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		next_key = {w0, w1, w2, w3};
	endfunction

endpackage

// ===== rtl/core/aes_stream_if.sv =====
interface aes_stream_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_high;
	logic [63:0] data_low;

	modport source (output valid, output data_high, output data_low, input ready);
	modport sink   (input valid, input data_high, input data_low, output ready);
endinterface

// ===== rtl/core/aes128_block_encrypt.sv =====
// Channel  | Dir | Payload                              | Handshake
// plain    | in  | data_high = plain_high, data_low = plain_low   | valid/ready
// cipher   | out | data_high = cipher_high, data_low = cipher_low | valid/ready
// cfg      | in  | cfg_we, cfg_idx (0 key_high, 1 key_low), cfg_wdata | write only
//
// Eleven register stages: initial key add, then one stage per round.
// One request per cycle sustained while the output is not stalled.
// Round keys ride along the pipeline with each request, expanded one step per stage.
// A stall at the output freezes the whole pipe, except that bubbles are filled.
// arst_n clears the valid bits and both key registers.
module aes128_block_encrypt
	import aes_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	aes_stream_if.sink          plain,
	aes_stream_if.source        cipher,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [63:0]         cfg_wdata
);

	logic [63:0] key_high_q, key_low_q;

	// Pipeline stage registers: index 0 is after the initial key add
	logic        vld_s [NumRounds+1];
	blk_t        st_s  [NumRounds+1];
	blk_t        key_s [NumRounds+1];
	logic        adv   [NumRounds+1];

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_KEY_HIGH: key_high_q <= cfg_wdata;
				REG_KEY_LOW:  key_low_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Stage loads when it is empty or its content moves on
	always_comb begin
		adv[NumRounds] = !vld_s[NumRounds] || cipher.ready;
		for (int i = NumRounds - 1; i >= 0; i--)
			adv[i] = !vld_s[i] || adv[i+1];
	end

	assign plain.ready = adv[0];

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NumRounds; i++)
				vld_s[i] <= 1'b0;
		end else begin
			if (adv[0])
				vld_s[0] <= plain.valid;
			for (int i = 1; i <= NumRounds; i++)
				if (adv[i])
					vld_s[i] <= vld_s[i-1];
		end
	end

	// Stage 0: initial AddRoundKey
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			st_s[0]  <= {plain.data_high, plain.data_low} ^ {key_high_q, key_low_q};
			key_s[0] <= {key_high_q, key_low_q};
		end
	end

	// Rounds 1..10, one per stage
	for (genvar r = 1; r <= NumRounds; r++) begin : g_round
		blk_t rk;
		blk_t sb;
		assign rk = next_key(key_s[r-1], RCON[r]);
		assign sb = sub_shift(st_s[r-1]);
		always_ff @(posedge clk) begin
			if (adv[r]) begin
				key_s[r] <= rk;
				if (r == NumRounds)
					st_s[r] <= sb ^ rk;
				else
					st_s[r] <= mix_columns(sb) ^ rk;
			end
		end
	end

	assign cipher.valid     = vld_s[NumRounds];
	assign cipher.data_high = st_s[NumRounds][127:64];
	assign cipher.data_low  = st_s[NumRounds][63:0];

endmodule
